[hw/rtl/assert_macros.svh]
// Assertion macros used by the block decompressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// Implication checked in the cycle after the condition.
`define CHK_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

[hw/rtl/snappy_pkg.sv]
// Package with shared types and constants for the Snappy block decompressor.
package snappy_pkg;
   localparam int unsigned BYTE_W = 8;
   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_COPY1 = 2'd1;
   localparam logic [1:0] KIND_COPY2 = 2'd2;
   localparam logic [1:0] KIND_COPY4 = 2'd3;
   localparam logic [5:0] LIT_LEN_EXT = 6'd60;
   localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_error;
      logic       last_in_run;
      logic       stream_done;
   } rsp_item_type;
endpackage

[hw/rtl/snappy_history.sv]
// History memory with one write port and one registered read port.
module snappy_history #(
   parameter int unsigned DEPTH = 65536,
   parameter int unsigned AW = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [snappy_pkg::BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [snappy_pkg::BYTE_W-1:0] rd_data
);
   import snappy_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/snappy_block_decompressor.sv]
// Top level of the Snappy block decompressor: parser, copy sequencer and output stage.
//
// The req_ channel takes one compressed byte per transfer: req_tdata is the byte and
// req_tuser marks the first byte of a new stream, which clears all parse state.
// The rsp_ channel gives decompressed bytes: rsp_tdata is the byte, rsp_tuser holds
// the error and stream_done flags, and rsp_tlast marks the last result of one input.
// Header, tag and literal bytes give at most one result each; a literal byte
// appears on rsp_ in the cycle after its transfer.
// A copy of N bytes holds req_tready low while the sequencer reads history once a
// cycle unless the output stalls; it emits one byte per cycle after a registered
// read, and the next byte is accepted only after the N bytes have gone out.
// A bad copy offset or an overlong length header gives one error result; the block
// then drops bytes until a start of stream.
// Reset is synchronous and clears control state only; history needs no clearing.
// When the receiver stalls, one result waits in the output register and the block
// stops accepting input until it is taken.
`include "assert_macros.svh"
module snappy_block_decompressor #(
   parameter int unsigned HISTORY_DEPTH = 65536
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] compressed_byte
   input  logic       req_tuser,   // [0] start_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [1:0] rsp_tuser,   // [0] is_error, [1] stream_done
   output logic       rsp_tlast
);
   import snappy_pkg::*;

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);
   localparam int unsigned FW = AW + 1;

   typedef enum logic [2:0] {
      PH_VARINT, PH_TAG, PH_LITLEN, PH_LITDATA, PH_COPYOFF, PH_COPY, PH_DONE, PH_ERROR
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [AW-1:0]   wptr_ff, wptr_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [31:0]     produced_ff, produced_in;
   logic [31:0]     expected_ff, expected_in;
   logic [7:0]      tag_ff, tag_in;
   logic [31:0]     acc_ff, acc_in;
   logic [32:0]     remain_ff, remain_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [AW-1:0]   raddr_ff, raddr_in;
   logic            rpend_ff, rpend_in;
   logic            fwd_ff, fwd_in;
   logic [7:0]      fwd_byte_ff, fwd_byte_in;
   rsp_item_type    out_ff, out_in;
   logic            ovalid_ff, ovalid_in;

   logic            wr_en;
   logic [7:0]      wr_data;
   logic [7:0]      rd_data;
   logic [AW-1:0]   rd_addr;
   logic            out_free;
   logic            req_fire;

   assign out_free = !ovalid_ff || rsp_tready;
   assign req_tready = out_free && (phase_ff != PH_COPY);
   assign req_fire = req_tvalid && req_tready;

   snappy_history #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_hist (
      .clock(clock), .wr_en(wr_en), .wr_addr(wptr_ff), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_comb begin
      logic            start;
      phase_type       ph;
      logic [31:0]     exp_v, acc_v, off_v;
      logic [2:0]      cnt_v, need_v;
      logic [32:0]     rem_v;
      logic            prod;
      logic [7:0]      pbyte;
      logic [31:0]     prod_v;
      logic [AW-1:0]   wp_v;
      logic [FW-1:0]   fill_v;
      logic [AW:0]     diff_v;
      logic            is_last;
      logic [AW-1:0]   next_addr;

      phase_in    = phase_ff;
      wptr_in     = wptr_ff;
      fill_in     = fill_ff;
      produced_in = produced_ff;
      expected_in = expected_ff;
      tag_in      = tag_ff;
      acc_in      = acc_ff;
      remain_in   = remain_ff;
      cnt_in      = cnt_ff;
      raddr_in    = raddr_ff;
      rpend_in    = 1'b0;
      fwd_in      = fwd_ff;
      fwd_byte_in = fwd_byte_ff;
      out_in      = out_ff;
      ovalid_in   = ovalid_ff && !rsp_tready;
      wr_en       = 1'b0;
      wr_data     = 8'd0;
      rd_addr     = raddr_ff;
      prod        = 1'b0;
      pbyte       = 8'd0;
      start       = 1'b0;
      exp_v       = expected_ff;
      acc_v       = acc_ff;
      cnt_v       = cnt_ff;
      rem_v       = remain_ff;
      need_v      = 3'd4;
      off_v       = 32'd0;
      ph          = phase_ff;
      prod_v      = produced_ff;
      wp_v        = wptr_ff;
      fill_v      = fill_ff;
      diff_v      = '0;
      is_last     = 1'b0;
      next_addr   = raddr_ff;

      if (req_fire) begin
         start = req_tuser;
         if (start) begin
            wp_v = '0; fill_v = '0; prod_v = '0; exp_v = '0; ph = PH_VARINT;
            tag_in = '0; acc_v = '0; rem_v = '0; cnt_v = '0;
         end
         unique case (ph)
            PH_VARINT: begin
               exp_v = exp_v | (32'({25'd0, req_tdata[6:0]}) << (7 * cnt_v));
               cnt_v = cnt_v + 3'd1;
               if (req_tdata[7]) begin
                  if (cnt_v >= VARINT_MAX_BYTES) begin
                     ph = PH_ERROR;
                     out_in = '{data_byte: 8'd0, is_error: 1'b1, last_in_run: 1'b1,
                                stream_done: 1'b0};
                     ovalid_in = 1'b1;
                  end
               end else begin
                  cnt_v = '0;
                  ph = (exp_v == 32'd0) ? PH_DONE : PH_TAG;
               end
            end
            PH_TAG: begin
               tag_in = req_tdata;
               acc_v = '0;
               cnt_v = '0;
               case (req_tdata[1:0])
                  KIND_LITERAL: begin
                     if (req_tdata[7:2] < LIT_LEN_EXT) begin
                        rem_v = 33'(req_tdata[7:2]) + 33'd1;
                        ph = PH_LITDATA;
                     end else begin
                        ph = PH_LITLEN;
                     end
                  end
                  KIND_COPY1: begin
                     rem_v = 33'(req_tdata[4:2]) + 33'd4;
                     ph = PH_COPYOFF;
                  end
                  default: begin
                     rem_v = 33'(req_tdata[7:2]) + 33'd1;
                     ph = PH_COPYOFF;
                  end
               endcase
            end
            PH_LITLEN: begin
               acc_v = acc_v | (32'(req_tdata) << (8 * cnt_v[1:0]));
               cnt_v = cnt_v + 3'd1;
               if (cnt_v >= 3'(tag_ff[7:2] - 6'd59)) begin
                  rem_v = 33'(acc_v) + 33'd1;
                  ph = PH_LITDATA;
               end
            end
            PH_LITDATA: begin
               prod = 1'b1;
               pbyte = req_tdata;
               is_last = 1'b1;
               rem_v = rem_v - 33'd1;
               if (rem_v == 33'd0) ph = PH_TAG;
            end
            PH_COPYOFF: begin
               case (tag_ff[1:0])
                  KIND_COPY1: need_v = 3'd1;
                  KIND_COPY2: need_v = 3'd2;
                  default:    need_v = 3'd4;
               endcase
               acc_v = acc_v | (32'(req_tdata) << (8 * cnt_v[1:0]));
               cnt_v = cnt_v + 3'd1;
               if (cnt_v >= need_v) begin
                  off_v = (tag_ff[1:0] == KIND_COPY1) ? {21'd0, tag_ff[7:5], acc_v[7:0]}
                                                       : acc_v;
                  if (off_v == 32'd0 || off_v > 32'(fill_v)) begin
                     ph = PH_ERROR;
                     out_in = '{data_byte: 8'd0, is_error: 1'b1, last_in_run: 1'b1,
                                stream_done: 1'b0};
                     ovalid_in = 1'b1;
                  end else begin
                     diff_v = {1'b0, wp_v} - (AW + 1)'(off_v);
                     raddr_in = diff_v[AW] ? AW'(diff_v[AW-1:0] + AW'(HISTORY_DEPTH))
                                           : diff_v[AW-1:0];
                     rd_addr = raddr_in;
                     rpend_in = 1'b1;
                     fwd_in = 1'b0;
                     ph = PH_COPY;
                  end
               end
            end
            default: ;
         endcase
      end else if (phase_ff == PH_COPY && out_free) begin
         // The byte read last cycle goes out; a read of the byte being written
         // this cycle takes it from the forwarding register instead.
         if (rpend_ff) begin
            prod = 1'b1;
            pbyte = fwd_ff ? fwd_byte_ff : rd_data;
            rem_v = rem_v - 33'd1;
            is_last = (rem_v == 33'd0);
            if (is_last) ph = PH_TAG;
         end
         if (!is_last) begin
            next_addr = (raddr_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : raddr_ff + AW'(1);
            rd_addr = next_addr;
            raddr_in = next_addr;
            rpend_in = 1'b1;
            fwd_in = (next_addr == wptr_ff);
            fwd_byte_in = pbyte;
         end
      end else begin
         rpend_in = rpend_ff;
      end

      if (prod) begin
         wr_en = 1'b1;
         wr_data = pbyte;
         wp_v = (wp_v == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_v + AW'(1);
         if (fill_v < FW'(HISTORY_DEPTH)) fill_v = fill_v + FW'(1);
         prod_v = prod_v + 32'd1;
         out_in = '{data_byte: pbyte, is_error: 1'b0, last_in_run: 1'b0,
                    stream_done: (prod_v == exp_v)};
         if (prod_v == exp_v) begin
            ph = PH_DONE;
            is_last = 1'b1;
         end
         out_in.last_in_run = is_last;
         ovalid_in = 1'b1;
      end

      phase_in    = ph;
      wptr_in     = wp_v;
      fill_in     = fill_v;
      produced_in = prod_v;
      expected_in = exp_v;
      acc_in      = acc_v;
      remain_in   = rem_v;
      cnt_in      = cnt_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_VARINT;
         wptr_ff     <= '0;
         fill_ff     <= '0;
         produced_ff <= '0;
         expected_ff <= '0;
         tag_ff      <= '0;
         acc_ff      <= '0;
         remain_ff   <= '0;
         cnt_ff      <= '0;
         rpend_ff    <= 1'b0;
         fwd_ff      <= 1'b0;
         ovalid_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         wptr_ff     <= wptr_in;
         fill_ff     <= fill_in;
         produced_ff <= produced_in;
         expected_ff <= expected_in;
         tag_ff      <= tag_in;
         acc_ff      <= acc_in;
         remain_ff   <= remain_in;
         cnt_ff      <= cnt_in;
         rpend_ff    <= rpend_in;
         fwd_ff      <= fwd_in;
         ovalid_ff   <= ovalid_in;
      end
      raddr_ff    <= raddr_in;
      fwd_byte_ff <= fwd_byte_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff.data_byte;
   assign rsp_tuser  = {out_ff.stream_done, out_ff.is_error};
   assign rsp_tlast  = out_ff.last_in_run;

   `CHK_IMPL(a_no_accept_in_copy, clock, reset, phase_ff == PH_COPY, !req_tready,
             "input accepted during copy")
   `CHK_IMPL(a_err_fields, clock, reset, rsp_tvalid && rsp_tuser[0],
             rsp_tlast && !rsp_tuser[1] && rsp_tdata == 8'd0, "bad error result")
   `CHK_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(HISTORY_DEPTH),
             "history fill overflow")
   `CHK_NEXT(a_done_halts, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser[1] &&
             phase_ff == PH_DONE && !req_fire, phase_ff == PH_DONE, "left done state")
endmodule
